@@ rtl/core/rbe_pkg.sv @@
// Package for the rigid body Euler step: widths, codes, unit status type,
// saturation and magnitude helpers. No dependencies.
`default_nettype none
package rbe_pkg;
  localparam int DATA_W   = 32;
  localparam int MUL_W    = 40;
  localparam int PROD_W   = 2 * MUL_W;
  localparam logic [19:0] GRAV_MAG = 20'd642253;   // 9.8 in Q16.16

  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_IMPULSE = 2'd1;
  localparam logic [1:0] CMD_SLEEP   = 2'd2;
  localparam logic [1:0] CMD_UNUSED  = 2'd3;   // no operation, state unchanged

  localparam logic [1:0] CFG_GRAVITY   = 2'd0;
  localparam logic [1:0] CFG_FRICTION  = 2'd1;
  localparam logic [1:0] CFG_THRESHOLD = 2'd2;

  localparam logic signed [33:0] VMAX34 = 34'sd2147483647;
  localparam logic signed [33:0] VMIN34 = -VMAX34 - 34'sd1;

  // status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] x);
    if (x > VMAX34) return 32'sh7FFFFFFF;
    else if (x < VMIN34) return 32'sh80000000;
    else return x[31:0];
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] x);
    return x[31] ? 32'(-x) : 32'(x);
  endfunction
endpackage
`default_nettype wire

@@ rtl/core/rbe_mul.sv @@
// Serial shift-add multiplier, one multiplier bit per cycle, early finish.
// Depends on rbe_pkg.
`default_nettype none
module rbe_mul (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [rbe_pkg::MUL_W-1:0]   a,
  input  wire logic [rbe_pkg::MUL_W-1:0]   b,
  output logic [rbe_pkg::PROD_W-1:0]       p,
  output rbe_pkg::unit_stat_t              stat
);
  logic [rbe_pkg::PROD_W-1:0] ma;
  logic [rbe_pkg::MUL_W-1:0]  mb;
  logic [rbe_pkg::PROD_W-1:0] acc;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
      end else if (stat.busy && mb == '0) begin
        stat.busy <= 1'b0;
        stat.done <= 1'b1;
      end
    end
  end

  // datapath: add the shifted multiplicand for each set bit
  always_ff @(posedge clk) begin
    if (start) begin
      ma  <= {{(rbe_pkg::PROD_W-rbe_pkg::MUL_W){1'b0}}, a};
      mb  <= b;
      acc <= '0;
    end else if (stat.busy && mb != '0) begin
      if (mb[0]) acc <= acc + ma;
      ma <= ma << 1;
      mb <= mb >> 1;
    end
  end

  assign p = acc;
endmodule
`default_nettype wire

@@ rtl/core/rbe_isqrt.sv @@
// Integer square root of a 64-bit value, two radicand bits per cycle (32 steps).
// Depends on rbe_pkg.
`default_nettype none
module rbe_isqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] x,
  output logic [32:0]      root,
  output rbe_pkg::unit_stat_t stat
);
  logic [63:0] xr;
  logic [63:0] r;
  logic [63:0] bitv;
  logic [63:0] trial;

  assign trial = r + bitv;

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
      end else if (stat.busy && bitv == '0) begin
        stat.busy <= 1'b0;
        stat.done <= 1'b1;
      end
    end
  end

  // one result bit per step
  always_ff @(posedge clk) begin
    if (start) begin
      xr   <= x;
      r    <= '0;
      bitv <= 64'h4000_0000_0000_0000;
    end else if (stat.busy && bitv != '0) begin
      if (xr >= trial) begin
        xr <= xr - trial;
        r  <= (r >> 1) + bitv;
      end else begin
        r  <= r >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

  assign root = r[32:0];
endmodule
`default_nettype wire

@@ rtl/core/rbe_div.sv @@
// Restoring divider, 64-bit dividend by 33-bit divisor, one quotient bit per cycle.
// Depends on rbe_pkg.
`default_nettype none
module rbe_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] n,
  input  wire logic [32:0] d,
  output logic [31:0]      q,
  output rbe_pkg::unit_stat_t stat
);
  logic [63:0] nq;     // dividend shifts out, quotient shifts in
  logic [32:0] rem;
  logic [32:0] dr;
  logic [6:0]  cnt;
  logic [33:0] trial;
  logic        take;

  assign trial = {rem, nq[63]};
  assign take  = trial >= {1'b0, dr};

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
        cnt       <= 7'd64;
      end else if (stat.busy) begin
        if (cnt == 7'd1) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
        cnt <= cnt - 7'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nq  <= n;
      rem <= '0;
      dr  <= d;
    end else if (stat.busy) begin
      rem <= take ? 33'(trial - {1'b0, dr}) : trial[32:0];
      nq  <= {nq[62:0], take};
    end
  end

  assign q = nq[31:0];
endmodule
`default_nettype wire

@@ rtl/core/rigid_body_euler_friction_step.sv @@
// Rigid body Euler step with friction: sequencer over one serial multiplier,
// a serial square root and a serial divider. A dead-owner tick or an unused
// command goes straight to the output, and an impulse with a zero direction
// ends after the direction check. Each product runs one step per significant
// bit of its second operand; the divide takes 64 steps. One item at a time; the
// next item is taken while a result waits in the output register. Reset clears
// the velocity, loads gravity_enable 1, friction_scale 0, sleep_threshold 0.
// Depends on rbe_pkg, rbe_mul, rbe_isqrt, rbe_div.
`default_nettype none
module rigid_body_euler_friction_step (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [30:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         cmd,
  input  wire logic [15:0]        dt,
  input  wire logic               on_ground,
  input  wire logic               owner_dead,
  input  wire logic signed [31:0] pos_x,
  input  wire logic signed [31:0] pos_y,
  input  wire logic signed [31:0] pos_z,
  input  wire logic signed [31:0] dir_x,
  input  wire logic signed [31:0] dir_y,
  input  wire logic signed [31:0] dir_z,
  input  wire logic signed [31:0] force_req,
  input  wire logic               clear,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      new_pos_x,
  output logic signed [31:0]      new_pos_y,
  output logic signed [31:0]      new_pos_z,
  output logic signed [31:0]      vel_out_x,
  output logic signed [31:0]      vel_out_y,
  output logic signed [31:0]      vel_out_z,
  output logic                    sleeping
);
  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_GRAV  = 5'd1;
  localparam logic [4:0] ST_ZCHK  = 5'd2;
  localparam logic [4:0] ST_POS   = 5'd3;
  localparam logic [4:0] ST_KMUL  = 5'd4;
  localparam logic [4:0] ST_FMUL  = 5'd5;
  localparam logic [4:0] ST_FSQ   = 5'd6;
  localparam logic [4:0] ST_VSQ   = 5'd7;
  localparam logic [4:0] ST_FRIC  = 5'd8;
  localparam logic [4:0] ST_TSQ   = 5'd9;
  localparam logic [4:0] ST_INORM = 5'd10;
  localparam logic [4:0] ST_ISQ   = 5'd11;
  localparam logic [4:0] ST_ROOT  = 5'd12;
  localparam logic [4:0] ST_IMUL  = 5'd13;
  localparam logic [4:0] ST_IDIV  = 5'd14;
  localparam logic [4:0] ST_OUT   = 5'd15;

  localparam int MW = rbe_pkg::MUL_W;
  localparam int PW = rbe_pkg::PROD_W;

  logic [4:0] state;
  logic       pend;
  logic [1:0] idx;

  // configuration
  logic        grav_en;
  logic [15:0] fric_scale;
  logic [30:0] thr;

  // state and item
  logic signed [31:0] vel [3];
  logic signed [31:0] pos_r [3];
  logic signed [31:0] dir_r [3];
  logic [31:0]        dmag [3];
  logic [1:0]         cmd_r;
  logic [15:0]        dt_r;
  logic               ground_r;
  logic signed [31:0] force_r;
  logic               asleep;

  // intermediates
  logic [31:0]   kgain;
  logic [39:0]   fmag [2];
  logic [PW-1:0] acc_f;     // friction square sum, also impulse s2 and product
  logic [PW-1:0] acc_v;     // velocity square sum
  logic [32:0]   len;

  // units
  logic                mul_start, sq_start, dv_start;
  logic [MW-1:0]       mul_a, mul_b;
  logic [PW-1:0]       mul_p;
  logic [32:0]         root;
  logic [31:0]         quo;
  rbe_pkg::unit_stat_t mstat, sstat, dstat;

  rbe_mul u_mul (.clk, .rst, .start(mul_start), .a(mul_a), .b(mul_b), .p(mul_p),
                 .stat(mstat));
  rbe_isqrt u_sqrt (.clk, .rst, .start(sq_start), .x(acc_f[63:0]), .root,
                    .stat(sstat));
  rbe_div u_div (.clk, .rst, .start(dv_start), .n(acc_f[63:0]), .d(len), .q(quo),
                 .stat(dstat));

  logic [31:0] vmag_i;
  logic        grav_on;
  logic        vel_zero;
  assign vmag_i   = rbe_pkg::mag32(vel[idx]);
  assign grav_on  = grav_en && !ground_r;
  assign vel_zero = vel[0] == '0 && vel[1] == '0 && vel[2] == '0;

  // multiplier operands by step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_GRAV: begin mul_a = MW'(rbe_pkg::GRAV_MAG); mul_b = MW'(dt_r); end
      ST_POS:  begin mul_a = MW'(vmag_i);            mul_b = MW'(dt_r); end
      ST_KMUL: begin mul_a = MW'(fric_scale);        mul_b = MW'(dt_r); end
      ST_FMUL: begin mul_a = MW'(kgain);             mul_b = MW'(vmag_i); end
      ST_FSQ:  begin mul_a = fmag[idx[0]];           mul_b = fmag[idx[0]]; end
      ST_VSQ:  begin mul_a = MW'(vmag_i);            mul_b = MW'(vmag_i); end
      ST_TSQ:  begin mul_a = MW'(thr);               mul_b = MW'(thr); end
      ST_ISQ:  begin mul_a = MW'(dmag[idx]);         mul_b = MW'(dmag[idx]); end
      ST_IMUL: begin mul_a = MW'(dmag[idx]);
                     mul_b = MW'(rbe_pkg::mag32(force_r)); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign mul_start = !pend && (state == ST_POS || state == ST_KMUL || state == ST_FMUL ||
                     state == ST_FSQ || state == ST_VSQ || state == ST_TSQ ||
                     state == ST_ISQ || state == ST_IMUL ||
                     (state == ST_GRAV && grav_on));
  assign sq_start  = !pend && state == ST_ROOT;
  assign dv_start  = !pend && state == ST_IDIV;

  // product >> 16, rounded toward minus infinity for a negative sign
  logic [48:0]        pm_round;
  logic [32:0]        up_neg;
  logic signed [33:0] d_pos, d_grav, d_imp;
  logic signed [33:0] sum_pos, sum_grav, sum_imp;
  logic               imp_sub;
  assign pm_round = {1'b0, mul_p[47:0]} + 49'h0FFFF;
  assign up_neg   = pm_round[48:16];
  assign d_pos    = vel[idx][31] ? -$signed({1'b0, up_neg}) : $signed({2'b00, mul_p[47:16]});
  assign d_grav   = -$signed({1'b0, up_neg});
  assign imp_sub  = dir_r[idx][31] != force_r[31];
  assign d_imp    = imp_sub ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
  assign sum_pos  = {{2{pos_r[idx][31]}}, pos_r[idx]} + d_pos;
  assign sum_grav = {{2{vel[1][31]}}, vel[1]} + d_grav;
  assign sum_imp  = {{2{vel[idx][31]}}, vel[idx]} + d_imp;

  // friction applied per horizontal component
  logic signed [31:0] vfx, vfz;
  always_comb begin
    logic [31:0] mx, mz;
    mx = rbe_pkg::mag32(vel[0]);
    mz = rbe_pkg::mag32(vel[2]);
    if (fmag[0] >= {8'd0, mx}) vfx = '0;
    else vfx = vel[0][31] ? vel[0] + $signed(fmag[0][31:0]) : vel[0] - $signed(fmag[0][31:0]);
    if (fmag[1] >= {8'd0, mz}) vfz = '0;
    else vfz = vel[2][31] ? vel[2] + $signed(fmag[1][31:0]) : vel[2] - $signed(fmag[1][31:0]);
  end

  assign in_ready = state == ST_IDLE;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      grav_en    <= 1'b1;
      fric_scale <= '0;
      thr        <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rbe_pkg::CFG_GRAVITY:   grav_en    <= cfg_data[0];
        rbe_pkg::CFG_FRICTION:  fric_scale <= cfg_data[15:0];
        rbe_pkg::CFG_THRESHOLD: thr        <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pend      <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
      vel[0]    <= '0;
      vel[1]    <= '0;
      vel[2]    <= '0;
    end else begin
      // result taken; ST_OUT handles its own refill
      if (out_valid && out_ready && state != ST_OUT) out_valid <= 1'b0;
      if (mul_start || sq_start || dv_start) pend <= 1'b1;
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            cmd_r    <= cmd;
            dt_r     <= dt;
            ground_r <= on_ground;
            force_r  <= force_req;
            pos_r[0] <= pos_x;  pos_r[1] <= pos_y;  pos_r[2] <= pos_z;
            dir_r[0] <= dir_x;  dir_r[1] <= dir_y;  dir_r[2] <= dir_z;
            dmag[0]  <= rbe_pkg::mag32(dir_x);
            dmag[1]  <= rbe_pkg::mag32(dir_y);
            dmag[2]  <= rbe_pkg::mag32(dir_z);
            asleep   <= 1'b0;
            idx      <= '0;
            acc_v    <= '0;
            acc_f    <= '0;
            unique case (cmd)
              rbe_pkg::CMD_TICK:    state <= owner_dead ? ST_OUT : ST_GRAV;
              rbe_pkg::CMD_IMPULSE: begin
                if (clear) begin
                  vel[0] <= '0; vel[1] <= '0; vel[2] <= '0;
                end
                state <= ST_INORM;
              end
              rbe_pkg::CMD_SLEEP:   state <= ST_VSQ;
              default:              state <= ST_OUT;
            endcase
          end
        end
        ST_GRAV: begin
          if (!grav_on) state <= ST_ZCHK;
          else if (mstat.done) begin
            pend   <= 1'b0;
            vel[1] <= rbe_pkg::sat32(sum_grav);
            state  <= ST_ZCHK;
          end
        end
        ST_ZCHK: begin
          idx   <= '0;
          state <= vel_zero ? ST_OUT : ST_POS;
        end
        ST_POS: begin
          if (mstat.done) begin
            pend       <= 1'b0;
            pos_r[idx] <= rbe_pkg::sat32(sum_pos);
            if (idx == 2'd2) state <= ST_KMUL;
            else idx <= idx + 2'd1;
          end
        end
        ST_KMUL: begin
          if (mstat.done) begin
            pend  <= 1'b0;
            kgain <= mul_p[31:0];
            idx   <= '0;
            state <= ST_FMUL;
          end
        end
        ST_FMUL: begin
          // x then z
          if (mstat.done) begin
            pend          <= 1'b0;
            fmag[idx[1]]  <= {1'b0, mul_p[62:24]};
            if (idx == 2'd2) begin
              idx   <= '0;
              state <= ST_FSQ;
            end else idx <= 2'd2;
          end
        end
        ST_FSQ: begin
          if (mstat.done) begin
            pend  <= 1'b0;
            acc_f <= acc_f + mul_p;
            if (idx == 2'd1) begin
              idx   <= '0;
              state <= ST_VSQ;
            end else idx <= 2'd1;
          end
        end
        ST_VSQ: begin
          if (mstat.done) begin
            pend  <= 1'b0;
            acc_v <= acc_v + mul_p;
            if (idx == 2'd2) state <= (cmd_r == rbe_pkg::CMD_TICK) ? ST_FRIC : ST_TSQ;
            else idx <= idx + 2'd1;
          end
        end
        ST_FRIC: begin
          if (acc_f >= acc_v) begin
            vel[0] <= '0; vel[1] <= '0; vel[2] <= '0;
          end else begin
            vel[0] <= vfx;
            vel[2] <= vfz;
          end
          state <= ST_OUT;
        end
        ST_TSQ: begin
          if (mstat.done) begin
            pend <= 1'b0;
            if (acc_v < mul_p) begin
              asleep <= 1'b1;
              vel[0] <= '0; vel[1] <= '0; vel[2] <= '0;
            end
            state <= ST_OUT;
          end
        end
        ST_INORM: begin
          // scale the direction up until its largest component reaches 2^30
          if (dmag[0] == '0 && dmag[1] == '0 && dmag[2] == '0) state <= ST_OUT;
          else if ((dmag[0][31:30] | dmag[1][31:30] | dmag[2][31:30]) == 2'b00) begin
            dmag[0] <= dmag[0] << 1;
            dmag[1] <= dmag[1] << 1;
            dmag[2] <= dmag[2] << 1;
          end else begin
            idx   <= '0;
            state <= ST_ISQ;
          end
        end
        ST_ISQ: begin
          if (mstat.done) begin
            pend  <= 1'b0;
            acc_f <= acc_f + mul_p;
            if (idx == 2'd2) state <= ST_ROOT;
            else idx <= idx + 2'd1;
          end
        end
        ST_ROOT: begin
          if (sstat.done) begin
            pend  <= 1'b0;
            len   <= root;
            idx   <= '0;
            state <= (root == '0) ? ST_OUT : ST_IMUL;
          end
        end
        ST_IMUL: begin
          if (mstat.done) begin
            pend  <= 1'b0;
            acc_f <= mul_p;
            state <= ST_IDIV;
          end
        end
        ST_IDIV: begin
          if (dstat.done) begin
            pend     <= 1'b0;
            vel[idx] <= rbe_pkg::sat32(sum_imp);
            if (idx == 2'd2) state <= ST_OUT;
            else begin
              idx   <= idx + 2'd1;
              state <= ST_IMUL;
            end
          end
        end
        ST_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == ST_OUT && (!out_valid || out_ready)) begin
      new_pos_x <= pos_r[0];
      new_pos_y <= pos_r[1];
      new_pos_z <= pos_r[2];
      vel_out_x <= vel[0];
      vel_out_y <= vel[1];
      vel_out_z <= vel[2];
      sleeping  <= asleep;
    end
  end

  // no unit work outstanding while waiting for an item
  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst) in_ready |-> !pend)
    else $error("unit request outstanding while idle");
  // an outstanding request always has a unit at work or finishing
  a_pend_unit: assert property (@(posedge clk) disable iff (rst)
      pend |-> (mstat.busy || mstat.done || sstat.busy || sstat.done ||
                dstat.busy || dstat.done))
    else $error("pending request with no unit active");
  // a sleeping result carries zero velocity
  a_sleep_zero: assert property (@(posedge clk) disable iff (rst)
      out_valid && sleeping |-> vel_out_x == '0 && vel_out_y == '0 && vel_out_z == '0)
    else $error("sleeping result with nonzero velocity");
  // only one serial unit runs at a time
  a_one_unit: assert property (@(posedge clk) disable iff (rst)
      $countones({mstat.busy, sstat.busy, dstat.busy}) <= 1)
    else $error("more than one arithmetic unit busy");
endmodule
`default_nettype wire
